@@ rtl/core/ltsa_pkg.sv @@
// Package for the long-term spectral averager: payload structs, constants,
// and shared types. Depends on nothing.
`default_nettype none
package ltsa_pkg;

  localparam int MaxBinsDefault   = 512;
  localparam int MaxFramesDefault = 65535;
  localparam int MsPerSecond      = 1000;
  localparam int SumW             = 48;
  localparam int TimeW            = 48;

  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam logic CFG_INTERVAL = 1'b0;
  localparam logic CFG_NUM_BINS = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [8:0]  bin_index;
    logic [47:0] time_ms;
    logic [47:0] frame_sample;
    logic [31:0] frame_len;
    logic [31:0] power;
  } in_item_t;

  typedef struct packed {
    logic [47:0] period_start_ms;
    logic [47:0] period_end_ms;
    logic [15:0] frame_count;
    logic [47:0] first_sample;
    logic [47:0] span_samples;
    logic [8:0]  out_bin;
    logic [15:0] magnitude;
    logic        last_bin;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_CLEAR,
    ST_READ,
    ST_UPDATE,
    ST_MATH,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

@@ rtl/core/long_term_spectral_averager.sv @@
// Long-term spectral averager. One request carries one bin. A frame bin
// that only accumulates reads the sum memory, adds and writes back. A bin
// that emits a result (closing frame or flush) adds a divide by the frame
// count and a square root. The first bin 0 after reset or a num_bins write
// aligns the period with a divide and then clears the min(MAX_BINS, 512)
// entries of the sum memory at one entry a cycle. After reset a clearing
// pass over the same entries runs before the first request is taken;
// configuration must be written only while no request is in flight; the
// block does not enforce this. The result register is freed before the
// next request is taken.
`default_nettype none
module long_term_spectral_averager #(
  parameter int MAX_BINS   = ltsa_pkg::MaxBinsDefault,
  parameter int MAX_FRAMES = ltsa_pkg::MaxFramesDefault
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ltsa_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ltsa_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [16:0]         cfg_data
);
  localparam int Limit = (MAX_BINS < 512) ? MAX_BINS : 512;
  localparam int AW    = (Limit > 1) ? $clog2(Limit) : 1;
  localparam int FW    = $clog2(MAX_FRAMES + 1);
  localparam int SW    = ltsa_pkg::SumW;
  localparam logic [SW-1:0] SumMax = '1;

  // Configuration and period state.
  logic [16:0]   period_secs;
  logic [9:0]    num_bins;
  logic [SW-1:0] period_start, period_end, period_first, period_last;
  logic [FW-1:0] frames;
  logic          aligned, closing;

  // Sum memory with registered read.
  logic [SW-1:0] mem [Limit];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [SW-1:0] mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  ltsa_pkg::state_t state, state_next;
  ltsa_pkg::in_item_t req;
  logic [AW:0]   clr_cnt;
  logic          emit;
  logic          rst_pass;
  logic          al_run;

  // Derived values of the held request.
  logic [9:0]  nb;
  logic [26:0] ims;
  logic        last, in_range, is_flush;
  assign nb       = (num_bins == 10'd0) ? 10'd1
                  : (num_bins > 10'(Limit)) ? 10'(Limit) : num_bins;
  assign ims      = 27'(period_secs * 27'(ltsa_pkg::MsPerSecond));
  assign last     = ({1'b0, req.bin_index} == nb - 10'd1);
  assign in_range = ({1'b0, req.bin_index} < nb);
  assign is_flush = (req.req_type == ltsa_pkg::REQ_FLUSH);

  logic al_start, al_done, dv_start, dv_done, sq_start, sq_done;
  logic [SW-1:0] al_ms, quot;
  logic [15:0]   root;

  ltsa_align u_align (
    .clk(clk), .rst(rst), .start(al_start), .time_ms(req.time_ms), .ims(ims),
    .done(al_done), .aligned_ms(al_ms)
  );
  ltsa_div #(.DW(FW)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .dividend(mem_rdata),
    .divisor(frames), .done(dv_done), .quotient(quot)
  );
  ltsa_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .value(quot),
    .done(sq_done), .root(root)
  );

  assign in_stall = (state != ltsa_pkg::ST_IDLE) || out_valid;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ltsa_pkg::ST_IDLE:
        if (in_valid && !in_stall) begin
          state_next = ltsa_pkg::ST_ALIGN;
        end
      ltsa_pkg::ST_ALIGN: begin
        if (!in_range) begin
          state_next = ltsa_pkg::ST_IDLE;
        end else if (is_flush) begin
          state_next = (frames == '0) ? ltsa_pkg::ST_IDLE : ltsa_pkg::ST_READ;
        end else if (ims == '0) begin
          state_next = ltsa_pkg::ST_IDLE;
        end else if (req.bin_index == '0 && !aligned) begin
          if (al_done) begin
            state_next = ltsa_pkg::ST_CLEAR;
          end
        end else if (req.bin_index != '0 && !aligned) begin
          state_next = ltsa_pkg::ST_IDLE;
        end else begin
          state_next = ltsa_pkg::ST_READ;
        end
      end
      ltsa_pkg::ST_CLEAR:
        if (clr_cnt == (AW+1)'(Limit - 1)) begin
          state_next = (rst_pass) ? ltsa_pkg::ST_IDLE : ltsa_pkg::ST_ALIGN;
        end
      ltsa_pkg::ST_READ:   state_next = ltsa_pkg::ST_UPDATE;
      ltsa_pkg::ST_UPDATE: state_next = emit ? ltsa_pkg::ST_MATH : ltsa_pkg::ST_IDLE;
      ltsa_pkg::ST_MATH:   if (sq_done) state_next = ltsa_pkg::ST_IDLE;
      default:             state_next = ltsa_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = req.bin_index[AW-1:0];
    mem_wdata = '0;
    mem_raddr = req.bin_index[AW-1:0];
    al_start  = 1'b0;
    dv_start  = 1'b0;
    sq_start  = 1'b0;
    case (state)
      ltsa_pkg::ST_ALIGN:
        al_start = in_range && !is_flush && ims != '0 && req.bin_index == '0
                   && !aligned && !al_run;
      ltsa_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt[AW-1:0];
      end
      ltsa_pkg::ST_UPDATE: begin
        mem_we   = 1'b1;
        dv_start = emit;
        if (is_flush) begin
          mem_wdata = '0;
        end else if (emit) begin
          mem_wdata = SW'(req.power);
        end else if ((SW+1)'(mem_rdata) + (SW+1)'(req.power) > (SW+1)'(SumMax)) begin
          mem_wdata = SumMax;
        end else begin
          mem_wdata = mem_rdata + SW'(req.power);
        end
      end
      ltsa_pkg::ST_MATH:
        sq_start = dv_done;
      default: ;
    endcase
  end

  // Sequencer registers and period bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ltsa_pkg::ST_CLEAR;
      rst_pass         <= 1'b1;
      clr_cnt          <= '0;
      al_run           <= 1'b0;
      period_secs      <= 17'd60;
      num_bins         <= 10'd512;
      aligned          <= 1'b0;
      closing          <= 1'b0;
      frames           <= '0;
      period_start     <= '0;
      period_end       <= '0;
      period_first     <= '0;
      period_last      <= '0;
      out_valid        <= 1'b0;
      emit             <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_index == ltsa_pkg::CFG_INTERVAL) begin
          period_secs <= cfg_data;
        end else begin
          num_bins <= cfg_data[9:0];
          aligned  <= 1'b0;
        end
      end
      if (al_start) begin
        al_run <= 1'b1;
      end
      if (state == ltsa_pkg::ST_CLEAR) begin
        if (state_next != ltsa_pkg::ST_CLEAR) begin
          clr_cnt  <= '0;
          rst_pass <= 1'b0;
          if (!rst_pass) begin
            aligned <= 1'b1;
            al_run  <= 1'b0;
          end
        end else begin
          clr_cnt <= clr_cnt + 1'b1;
        end
      end
      if (state == ltsa_pkg::ST_ALIGN && al_done) begin
        period_start <= al_ms;
        period_end   <= al_ms + SW'(ims);
      end
      // Frame-level decision on bin 0 and the emit flag of every bin, on the way into the memory read.
      if (state == ltsa_pkg::ST_ALIGN && state_next == ltsa_pkg::ST_READ) begin
        if (is_flush) begin
          emit <= 1'b1;
        end else begin
          if (req.bin_index == '0) begin
            closing <= (req.time_ms >= period_end) && (frames != '0);
            emit    <= (req.time_ms >= period_end) && (frames != '0);
          end else begin
            emit <= closing;
          end
        end
      end
      if (state == ltsa_pkg::ST_MATH && sq_done) begin
        out_valid          <= 1'b1;
        out_data.magnitude <= root;
      end
      // Period bookkeeping after the result fields are captured.
      if (state == ltsa_pkg::ST_UPDATE) begin
        if (emit) begin
          out_data.period_start_ms <= period_start;
          out_data.period_end_ms   <= period_end;
          out_data.frame_count     <= 16'(frames);
          out_data.first_sample    <= period_first;
          out_data.span_samples    <= period_last - period_first;
          out_data.out_bin         <= req.bin_index;
          out_data.last_bin        <= last;
        end
        if (last) begin
          if (is_flush) begin
            period_start <= period_end;
            period_end   <= period_end + SW'(ims);
            frames       <= '0;
          end else begin
            if (closing) begin
              period_start <= period_end;
              period_end   <= period_end + SW'(ims);
              closing      <= 1'b0;
            end
            if (frames == '0 || closing) begin
              period_first <= req.frame_sample;
            end
            period_last <= req.frame_sample + SW'(req.frame_len);
            if (closing) begin
              frames <= FW'(1);
            end else if (frames < FW'(MAX_FRAMES)) begin
              frames <= frames + 1'b1;
            end
          end
        end
      end
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req <= in_data;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/ltsa_div.sv @@
// Restoring divider: 48-bit dividend by a DW-bit divisor, one quotient
// bit per cycle. Uses ltsa_pkg for widths.
`default_nettype none
module ltsa_div #(
  parameter int DW = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [ltsa_pkg::SumW-1:0]   dividend,
  input  wire logic [DW-1:0]               divisor,
  output logic                             done,
  output logic [ltsa_pkg::SumW-1:0]        quotient
);
  localparam int N  = ltsa_pkg::SumW;
  localparam int CW = $clog2(N + 1);

  logic [DW:0]   rem;
  logic [DW:0]   trial;
  logic [DW-1:0] dvsr;
  logic [CW-1:0] count;
  logic          busy;

  assign trial = {rem[DW-1:0], quotient[N-1]};

  // One shift-subtract step per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(N);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The divisor is held for the whole division.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvsr     <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (trial >= {1'b0, dvsr}) begin
        rem      <= trial - {1'b0, dvsr};
        quotient <= {quotient[N-2:0], 1'b1};
      end else begin
        rem      <= trial;
        quotient <= {quotient[N-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/ltsa_sqrt.sv @@
// Bit-pair integer square root of a 48-bit value, one result bit per cycle,
// saturated to 16 bits. Uses ltsa_pkg for widths.
`default_nettype none
module ltsa_sqrt (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [ltsa_pkg::SumW-1:0] value,
  output logic                           done,
  output logic [15:0]                    root
);
  localparam int N = ltsa_pkg::SumW;
  localparam int R = N / 2;

  logic [N-1:0] v;
  logic [R-1:0] res;
  logic [R+1:0] rem;
  logic [R+1:0] trial;
  logic [4:0]   count;
  logic         busy;

  assign trial = {rem[R-1:0], v[N-1:N-2]} - {res, 2'b01};
  assign root  = (|res[R-1:16]) ? 16'hFFFF : res[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 5'(R);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Two radicand bits enter per step; the trial remainder decides the bit.
  always_ff @(posedge clk) begin
    if (start) begin
      v   <= value;
      res <= '0;
      rem <= '0;
    end else if (busy) begin
      v <= {v[N-3:0], 2'b00};
      if (!trial[R+1]) begin
        rem <= trial;
        res <= {res[R-2:0], 1'b1};
      end else begin
        rem <= {rem[R-1:0], v[N-1:N-2]};
        res <= {res[R-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/ltsa_align.sv @@
// Period alignment: floor(time / interval) * interval by a restoring
// divide, one quotient bit per cycle, then one subtract. Uses ltsa_pkg.
`default_nettype none
module ltsa_align (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [ltsa_pkg::TimeW-1:0] time_ms,
  input  wire logic [26:0]                ims,
  output logic                            done,
  output logic [ltsa_pkg::TimeW-1:0]      aligned_ms
);
  localparam int N = ltsa_pkg::TimeW;

  logic [27:0]  rem;
  logic [27:0]  trial;
  logic [N-1:0] q;
  logic [N-1:0] t_hold;
  logic [5:0]   count;
  logic         busy;
  logic         mul;

  assign trial = {rem[26:0], q[N-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      mul   <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      mul  <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 6'(N);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          mul  <= 1'b1;
        end
      end
      if (mul) begin
        done <= 1'b1;
      end
    end
  end

  // The aligned time is the time less its remainder modulo the interval.
  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= '0;
      q      <= time_ms;
      t_hold <= time_ms;
    end else if (busy) begin
      if (trial >= {1'b0, ims}) begin
        rem <= trial - {1'b0, ims};
        q   <= {q[N-2:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[N-2:0], 1'b0};
      end
    end
    if (mul) begin
      aligned_ms <= t_hold - N'(rem);
    end
  end
endmodule
`default_nettype wire

@@ bench/long_term_spectral_averager_tb.sv @@
// Testbench for the long-term spectral averager: drives frame and flush
// requests, predicts every result with its own model and checks each one.
// Depends on ltsa_pkg and long_term_spectral_averager.
`timescale 1ns / 100ps

module long_term_spectral_averager_tb;

  localparam int ItemTarget = 1750;
  localparam int DrainPause = 700;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  ltsa_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ltsa_pkg::out_item_t out_data;
  logic                cfg_we = 1'b0;
  logic                cfg_index = ltsa_pkg::CFG_INTERVAL;
  logic [16:0]         cfg_data = '0;

  long_term_spectral_averager u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Averager state as the bench sees it.
  logic [47:0] bin_sum [512];
  int unsigned frames_held;
  logic [47:0] span_begin_ms, span_end_ms, first_smp, last_smp;
  bit          is_aligned, frame_closes;
  logic [16:0] interval_s;
  logic [9:0]  bins_reg;

  ltsa_pkg::out_item_t pending_avg[$];
  int          mismatches = 0;
  int          sent = 0;
  int          burst_left = 0;
  int          hold_left = 0;
  bit          hold_start = 0;
  int          stall_mode = 0;
  int unsigned cyc = 0;

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic int unsigned active_bins();
    if (bins_reg == 0) return 1;
    if (bins_reg > 512) return 512;
    return bins_reg;
  endfunction

  // Queue the average of one bin for the period that is being closed.
  function automatic void push_average(logic [8:0] b, bit last);
    ltsa_pkg::out_item_t r;
    logic [63:0] mean, mag;
    mean = 64'(bin_sum[b]) / 64'(frames_held);
    mag = floor_sqrt(mean);
    r.period_start_ms = span_begin_ms;
    r.period_end_ms   = span_end_ms;
    r.frame_count     = frames_held[15:0];
    r.first_sample    = first_smp;
    r.span_samples    = last_smp - first_smp;
    r.out_bin         = b;
    r.magnitude       = (mag > 65535) ? 16'hFFFF : mag[15:0];
    r.last_bin        = last;
    pending_avg.push_back(r);
  endfunction

  function automatic void next_period(logic [63:0] ims);
    span_begin_ms = span_end_ms;
    span_end_ms   = span_end_ms + ims[47:0];
    frames_held   = 0;
  endfunction

  // Apply one accepted request to the bench state.
  function automatic void average_bin(ltsa_pkg::in_item_t it);
    int unsigned nb;
    bit          last;
    logic [63:0] ims;
    logic [48:0] s;
    nb = active_bins();
    if (int'(it.bin_index) >= nb) return;
    last = (int'(it.bin_index) == nb - 1);
    ims = 64'(interval_s) * 64'(ltsa_pkg::MsPerSecond);
    if (it.req_type == ltsa_pkg::REQ_FLUSH) begin
      if (frames_held == 0) return;
      push_average(it.bin_index, last);
      bin_sum[it.bin_index] = '0;
      if (last) next_period(ims);
      return;
    end
    if (ims == 0) return;
    if (it.bin_index == 0) begin
      if (!is_aligned) begin
        span_begin_ms = 48'((64'(it.time_ms) / ims) * ims);
        span_end_ms = span_begin_ms + ims[47:0];
        foreach (bin_sum[i]) bin_sum[i] = '0;
        is_aligned = 1;
      end
      frame_closes = (it.time_ms >= span_end_ms) && (frames_held != 0);
    end else if (!is_aligned) begin
      return;
    end
    if (frame_closes) begin
      push_average(it.bin_index, last);
      bin_sum[it.bin_index] = 48'(it.power);
    end else begin
      s = {1'b0, bin_sum[it.bin_index]} + 49'(it.power);
      bin_sum[it.bin_index] = s[48] ? {48{1'b1}} : s[47:0];
    end
    if (last) begin
      if (frame_closes) begin
        next_period(ims);
        frame_closes = 0;
      end
      if (frames_held == 0) first_smp = it.frame_sample;
      last_smp = it.frame_sample + 48'(it.frame_len);
      if (frames_held < ltsa_pkg::MaxFramesDefault) frames_held++;
    end
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got 0x%0h, expected 0x%0h at %0t", field, got, want, $time);
    mismatches++;
  endtask

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin
    ltsa_pkg::out_item_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_avg.size() == 0) begin
        report_mismatch("unexpected result", out_data.out_bin, 0);
      end else begin
        w = pending_avg.pop_front();
        if (out_data.period_start_ms !== w.period_start_ms)
          report_mismatch("period_start_ms", out_data.period_start_ms, w.period_start_ms);
        if (out_data.period_end_ms !== w.period_end_ms)
          report_mismatch("period_end_ms", out_data.period_end_ms, w.period_end_ms);
        if (out_data.frame_count !== w.frame_count)
          report_mismatch("frame_count", out_data.frame_count, w.frame_count);
        if (out_data.first_sample !== w.first_sample)
          report_mismatch("first_sample", out_data.first_sample, w.first_sample);
        if (out_data.span_samples !== w.span_samples)
          report_mismatch("span_samples", out_data.span_samples, w.span_samples);
        if (out_data.out_bin !== w.out_bin)
          report_mismatch("out_bin", out_data.out_bin, w.out_bin);
        if (out_data.magnitude !== w.magnitude)
          report_mismatch("magnitude", out_data.magnitude, w.magnitude);
        if (out_data.last_bin !== w.last_bin)
          report_mismatch("last_bin", out_data.last_bin, w.last_bin);
      end
    end
  end

  // Output stall: a randomly redrawn mode, plus a long hold on demand.
  always @(posedge clk) begin
    cyc++;
    if (cyc % 256 == 0) stall_mode = $urandom_range(0, 2);
    if (hold_start) begin
      hold_left = 2000;
      hold_start = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_stall <= ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  end

  // Send one request; valid stays high within a burst.
  task automatic send_request(ltsa_pkg::in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    average_bin(it);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic quiesce_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every expected result, then let any work without a result finish.
  task automatic drain();
    quiesce_input();
    while (pending_avg.size() != 0) @(posedge clk);
    repeat (DrainPause) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [16:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ltsa_pkg::CFG_INTERVAL) begin
      interval_s = val;
    end else begin
      bins_reg = val[9:0];
      is_aligned = 0;
    end
  endtask

  function automatic ltsa_pkg::in_item_t make_req(logic kind, logic [8:0] b,
                                                  logic [47:0] t, logic [31:0] pw);
    ltsa_pkg::in_item_t it;
    it.req_type = kind;
    it.bin_index = b;
    it.time_ms = t;
    it.frame_sample = 48'({$urandom, $urandom});
    it.frame_len = $urandom;
    it.power = pw;
    return it;
  endfunction

  task automatic send_frame(logic [47:0] t, int unsigned nb);
    for (int unsigned b = 0; b < nb; b++)
      send_request(make_req(ltsa_pkg::REQ_FRAME, b[8:0], t, $urandom));
  endtask

  task automatic send_flush(int unsigned nb);
    for (int unsigned b = 0; b < nb; b++)
      send_request(make_req(ltsa_pkg::REQ_FLUSH, b[8:0], 48'({$urandom, $urandom}),
                            $urandom));
  endtask

  // Directed: empty flush, unaligned bin, power extremes, closing, aborted frame.
  task automatic test_directed();
    write_reg(ltsa_pkg::CFG_NUM_BINS, 17'd2);
    write_reg(ltsa_pkg::CFG_INTERVAL, 17'd1);
    send_request(make_req(ltsa_pkg::REQ_FLUSH, 9'd0, 48'd0, 32'd5));
    send_request(make_req(ltsa_pkg::REQ_FRAME, 9'd1, 48'd10, 32'd7));
    send_request(make_req(ltsa_pkg::REQ_FRAME, 9'd0, 48'd500, 32'd0));
    send_request(make_req(ltsa_pkg::REQ_FRAME, 9'd1, 48'd500, 32'hFFFF_FFFF));
    send_request(make_req(ltsa_pkg::REQ_FRAME, 9'd0, 48'd999, 32'hFFFF_FFFF));
    send_request(make_req(ltsa_pkg::REQ_FRAME, 9'd1, 48'd999, 32'hFFFF_FFFF));
    send_request(make_req(ltsa_pkg::REQ_FRAME, 9'd0, 48'd1000, 32'd1));
    send_request(make_req(ltsa_pkg::REQ_FRAME, 9'd1, 48'd1000, 32'd2));
    send_request(make_req(ltsa_pkg::REQ_FRAME, 9'd2, 48'd1000, 32'd3));
    send_request(make_req(ltsa_pkg::REQ_FRAME, 9'd511, 48'd1000, 32'd3));
    send_request(make_req(ltsa_pkg::REQ_FLUSH, 9'd511, 48'd1000, 32'd3));
    send_request(make_req(ltsa_pkg::REQ_FRAME, 9'd0, 48'd1500, 32'd9));
    send_request(make_req(ltsa_pkg::REQ_FRAME, 9'd0, 48'd2100, 32'd16));
    send_request(make_req(ltsa_pkg::REQ_FRAME, 9'd1, 48'd2100, 32'd25));
    send_flush(2);
    send_frame(48'd9000, 2);
    send_request(make_req(ltsa_pkg::REQ_FLUSH, 9'd1, 48'd0, 32'd0));
    send_request(make_req(ltsa_pkg::REQ_FLUSH, 9'd0, 48'd0, 32'd0));
    write_reg(ltsa_pkg::CFG_INTERVAL, 17'd0);
    send_frame(48'hFFFF_FFFF_FFFF, 2);
    send_flush(2);
  endtask

  // Register extremes, including clamped bin counts and the widest interval.
  task automatic test_register_extremes();
    write_reg(ltsa_pkg::CFG_INTERVAL, 17'd1);
    write_reg(ltsa_pkg::CFG_NUM_BINS, 17'd512);
    send_frame(48'd0, 512);
    send_frame(48'd1000, 512);
    write_reg(ltsa_pkg::CFG_NUM_BINS, 17'd0);
    send_frame(48'd5, 1);
    send_frame(48'd2500, 1);
    write_reg(ltsa_pkg::CFG_INTERVAL, 17'd131071);
    write_reg(ltsa_pkg::CFG_NUM_BINS, 17'd1023);
    for (int b = 0; b < 12; b++)
      send_request(make_req(ltsa_pkg::REQ_FRAME, b[8:0], 48'd7, $urandom));
    write_reg(ltsa_pkg::CFG_INTERVAL, 17'd86400);
    write_reg(ltsa_pkg::CFG_NUM_BINS, 17'd1);
    send_frame(48'hFFFF_FFFF_0000, 1);
    send_frame(48'hFFFF_FFFF_FFFF, 1);
    send_frame(48'd86400000, 1);
    send_flush(1);
  endtask

  // Receiver holds off while requests keep coming, then the sender waits it out.
  task automatic test_backpressure();
    write_reg(ltsa_pkg::CFG_INTERVAL, 17'd1);
    write_reg(ltsa_pkg::CFG_NUM_BINS, 17'd4);
    hold_start = 1;
    send_frame(48'd100, 4);
    for (int f = 1; f < 10; f++) send_frame(48'(f * 1000 + 100), 4);
    drain();
  endtask

  // Well-formed frames with random content, with noise and broken frames mixed in.
  task automatic test_random_frames();
    int unsigned nb, choice;
    logic [47:0] t;
    logic [63:0] ims;
    while (sent < ItemTarget) begin
      case ($urandom_range(0, 7))
        0: write_reg(ltsa_pkg::CFG_INTERVAL, 17'd2);
        1: write_reg(ltsa_pkg::CFG_INTERVAL, 17'd60);
        2: write_reg(ltsa_pkg::CFG_INTERVAL, 17'($urandom_range(0, 131071)));
        default: write_reg(ltsa_pkg::CFG_INTERVAL, 17'd1);
      endcase
      nb = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
      write_reg(ltsa_pkg::CFG_NUM_BINS, 17'(nb));
      ims = 64'(interval_s) * 1000;
      t = ($urandom_range(0, 1) == 0) ? 48'($urandom_range(0, 5000))
                                       : 48'({$urandom, $urandom});
      for (int f = 0; f < 40 && sent < ItemTarget; f++) begin
        choice = $urandom_range(0, 19);
        if (choice == 0) begin
          send_flush(nb);
        end else if (choice == 1) begin
          send_request(make_req(1'($urandom_range(0, 1)), 9'($urandom),
                                48'({$urandom, $urandom}), $urandom));
        end else if (choice == 2) begin
          for (int b = 0; b < $urandom_range(1, nb); b++)
            send_request(make_req(ltsa_pkg::REQ_FRAME, b[8:0], t, $urandom));
        end else begin
          send_frame(t, nb);
        end
        if (ims == 0 || $urandom_range(0, 2) != 0)
          t = t + 48'($urandom_range(0, 700));
        else
          t = t + 48'($urandom_range(0, 32'(2 * ims)));
      end
    end
    drain();
  endtask

  initial begin
    foreach (bin_sum[i]) bin_sum[i] = '0;
    frames_held = 0;
    span_begin_ms = '0;
    span_end_ms = '0;
    first_smp = '0;
    last_smp = '0;
    is_aligned = 0;
    frame_closes = 0;
    interval_s = 17'd60;
    bins_reg = 10'd512;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random_frames();
    drain();
    if (mismatches == 0 && pending_avg.size() == 0) begin
      $display("long_term_spectral_averager_tb OK");
    end else begin
      $display("long_term_spectral_averager_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("long_term_spectral_averager_tb NOT OK");
    $finish;
  end

endmodule
